FILE: sv/base64_stream_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream encoder.
// Both macros expect signals named clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Checked on every edge outside reset.
`define B64E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define B64E_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared widths, types and the base64 alphabet for the stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int BYTE_W      = 8;
  localparam int SYM_W       = 6;
  localparam int CHAR_W      = 7;
  localparam int MAX_CHARS   = 4;
  localparam int IDX_W       = $clog2(MAX_CHARS);
  localparam int CNT_W       = $clog2(MAX_CHARS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;  // '='

  // One byte's worth of work for the back end: the characters it yields,
  // first one in slot 0, and whether its last character ends the message.
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic [MAX_CHARS-1:0][CHAR_W-1:0]  chars;
    logic                              final_job;
  } job_t;

  // Map a six-bit value onto the standard alphabet.
  function automatic logic [CHAR_W-1:0] b64_char(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/b64e_stream_if.sv
// ----------------------------------------------------------------------------
// b64e stream interfaces
// Valid/ready channels for raw bytes in and base64 characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64e_byte_if;
  logic                        valid;
  logic                        ready;
  logic [b64e_pkg::BYTE_W-1:0] data_byte;
  logic                        end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface b64e_char_if;
  logic                        valid;
  logic                        ready;
  logic [b64e_pkg::CHAR_W-1:0] char_code;
  logic                        final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink   (input valid, char_code, final_char, output ready);
endinterface

`default_nettype wire

FILE: sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder: RFC 4648 base64 encoder, one byte in, one char out.
// A byte's job is registered in the queue, then its characters pass through
// the output register, one per cycle unless the output stalls. A byte yields
// 1 to 4 characters, a three-byte group 4; bursts run ahead by the queue
// depth. Reset clears the group phase, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  b64e_byte_if.sink   byte_in,
  b64e_char_if.source char_out
);

  b64e_pkg::job_t front_job, head_job;
  logic           front_valid, front_ready;
  logic           head_valid, head_ready;

  // Byte classification and group state.
  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // Job queue between the two halves.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_job    (head_job)
  );

  // Character sequencing and output register.
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job_ready (head_ready),
    .job       (head_job),
    .char_out  (char_out)
  );

endmodule

`default_nettype wire

FILE: sv/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group phase and carry bits, and turns each byte
// into a job of one to four characters for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic         clk,
  input  wire logic         rst,
  b64e_byte_if.sink         byte_in,
  output b64e_pkg::job_t    job,
  output logic              job_valid,
  input  wire logic         job_ready
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase, phase_next;
  logic [3:0] carry_bits, carry_next;
  logic       accept;

  // A beat is taken whenever the queue has room.
  assign byte_in.ready = job_ready;
  assign job_valid     = byte_in.valid;
  assign accept        = byte_in.valid && job_ready;

  // Build the job for the current byte and the next group state.
  always_comb begin
    logic [b64e_pkg::BYTE_W-1:0] b;
    logic                        last;
    b    = byte_in.data_byte;
    last = byte_in.end_of_message;
    job.chars     = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
    job.count     = b64e_pkg::CNT_W'(1);
    job.final_job = 1'b0;
    phase_next    = PH_FIRST;
    carry_next    = 4'd0;
    case (phase)
      PH_SECOND: begin
        job.chars[0] = b64e_pkg::b64_char({carry_bits[1:0], b[7:4]});
        if (last) begin
          job.chars[1]  = b64e_pkg::b64_char({b[3:0], 2'b00});
          job.count     = b64e_pkg::CNT_W'(3);
          job.final_job = 1'b1;
        end else begin
          carry_next = b[3:0];
          phase_next = PH_THIRD;
        end
      end
      PH_THIRD: begin
        job.chars[0]  = b64e_pkg::b64_char({carry_bits, b[7:6]});
        job.chars[1]  = b64e_pkg::b64_char(b[5:0]);
        job.count     = b64e_pkg::CNT_W'(2);
        job.final_job = last;
      end
      default: begin
        // First byte of a group; the unused phase code behaves the same.
        job.chars[0] = b64e_pkg::b64_char(b[7:2]);
        if (last) begin
          job.chars[1]  = b64e_pkg::b64_char({b[1:0], 4'b0000});
          job.count     = b64e_pkg::CNT_W'(4);
          job.final_job = 1'b1;
        end else begin
          carry_next = {2'b00, b[1:0]};
          phase_next = PH_SECOND;
        end
      end
    endcase
  end

  // Group state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      carry_bits <= 4'd0;
    end else if (accept) begin
      phase      <= phase_next;
      carry_bits <= carry_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small job FIFO that decouples the byte front end from the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH  // two or more
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire b64e_pkg::job_t  push_job,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output b64e_pkg::job_t       pop_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push, pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Steps through the characters of the head job, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire b64e_pkg::job_t  job,
  b64e_char_if.source          char_out
);

  logic                            out_valid;
  logic [b64e_pkg::CHAR_W-1:0]     char_code;
  logic                            final_char;
  logic [b64e_pkg::IDX_W-1:0]      idx;
  logic                            load;
  logic                            last_idx;

  assign char_out.valid      = out_valid;
  assign char_out.char_code  = char_code;
  assign char_out.final_char = final_char;

  // The output register can take a new beat when empty or being drained.
  assign load      = !out_valid || char_out.ready;
  assign last_idx  = ({1'b0, idx} == (job.count - b64e_pkg::CNT_W'(1)));
  assign job_ready = load && last_idx;

  // Control: output valid and position inside the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= job_valid;
      if (job_valid) begin
        idx <= last_idx ? '0 : idx + b64e_pkg::IDX_W'(1);
      end
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      char_code  <= job.chars[idx];
      final_char <= job.final_job && last_idx;
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the character output of the base64 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_encoder_assert.svh"

module b64e_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [b64e_pkg::CHAR_W-1:0] out_code,
  input wire logic                        out_final
);

  logic expect_pad;
  logic is_pad;
  logic in_alphabet;

  assign is_pad      = (out_code == b64e_pkg::PAD_CHAR);
  assign in_alphabet = (out_code >= 7'h41 && out_code <= 7'h5A) ||
                       (out_code >= 7'h61 && out_code <= 7'h7A) ||
                       (out_code >= 7'h30 && out_code <= 7'h39) ||
                       (out_code == 7'h2B) || (out_code == 7'h2F) || is_pad;

  // A non-final pad beat must be followed by the final pad beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_pad <= 1'b0;
    end else if (out_valid && out_ready) begin
      expect_pad <= is_pad && !out_final;
    end
  end

  `B64E_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "output valid after reset")
  `B64E_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid, "valid dropped on stall")
  `B64E_ASSERT(a_data_holds, out_valid && !out_ready |=> $stable(out_code) && $stable(out_final), "payload changed on stall")
  `B64E_ASSERT(a_alphabet, out_valid |-> in_alphabet, "character outside base64 alphabet")
  `B64E_ASSERT(a_pad_pair, out_valid && expect_pad |-> is_pad && out_final, "second pad missing")

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (char_out.valid),
  .out_ready (char_out.ready),
  .out_code  (char_out.char_code),
  .out_final (char_out.final_char)
);

`default_nettype wire

FILE: dv/base64_stream_encoder_test.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// Self-checking bench for the streaming base64 encoder. A short table of
// directed bytes opens the run, some with the encoded text spelled out, and
// random messages of random length follow. Every byte accepted on the input
// channel is fed to a local encoder model, and every character beat on the
// output channel is compared with the oldest expected character. Both
// channels stall at random, apart from one stretch that runs at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 405;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int DIR_ROWS     = 25;

  // Position inside the current three-byte group.
  typedef enum logic [1:0] {
    GRP_LEAD,
    GRP_MID,
    GRP_TAIL
  } grp_pos_e;

  // One expected character beat.
  typedef struct packed {
    logic [b64e_pkg::CHAR_W-1:0] code;
    logic                        fin;
  } char_beat_t;

  // One directed byte. A nonzero spelled field holds the characters this
  // byte must produce, right-aligned; zero means the model decides.
  typedef struct packed {
    logic [b64e_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic [31:0]                 spelled;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  b64e_byte_if byte_in ();
  b64e_char_if char_out ();

  base64_stream_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .char_out (char_out)
  );

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  dir_row_t directed_rows [0:DIR_ROWS-1] = '{
    // Single-byte messages at both extremes.
    '{8'h00, 1'b1, "AA=="},
    '{8'hFF, 1'b1, "/w=="},
    // Full groups of all ones and all zeros.
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b1, "//"},
    '{8'h00, 1'b0, "A"},
    '{8'h00, 1'b0, "A"},
    '{8'h00, 1'b1, "AA"},
    // Two-byte message with one pad, then a plain three-byte group.
    '{8'h4D, 1'b0, "T"},
    '{8'h61, 1'b1, "WE="},
    '{8'h4D, 1'b0, "T"},
    '{8'h61, 1'b0, "W"},
    '{8'h6E, 1'b1, "Fu"},
    // Message ends in the middle slot after different leftover bits.
    '{8'h00, 1'b0, 32'd0},
    '{8'hFF, 1'b1, 32'd0},
    '{8'hFF, 1'b0, 32'd0},
    '{8'h00, 1'b1, 32'd0},
    // Message ends in the last slot.
    '{8'hFF, 1'b0, 32'd0},
    '{8'h00, 1'b0, 32'd0},
    '{8'hFF, 1'b1, 32'd0},
    // Single high and low bits, then alternating patterns.
    '{8'h80, 1'b0, 32'd0},
    '{8'h01, 1'b0, 32'd0},
    '{8'h7F, 1'b1, 32'd0},
    '{8'h55, 1'b0, 32'd0},
    '{8'hAA, 1'b1, 32'd0}
  };

  // Encoder model state.
  grp_pos_e          grp_pos = GRP_LEAD;
  logic [3:0]        held_bits = '0;
  char_beat_t        expected_chars [$];

  logic [31:0]       beat_spelled;
  logic              no_stall;
  int                quiet_cycles = 0;
  int                bytes_sent;
  int                messages_sent;
  int                chars_checked = 0;
  int                mismatches = 0;

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Map a six-bit value onto the alphabet.
  function automatic logic [b64e_pkg::CHAR_W-1:0] sextet_char(input logic [5:0] v);
    byte c;
    c = alphabet[int'(v)];
    return c[b64e_pkg::CHAR_W-1:0];
  endfunction

  // Advance the model by one accepted byte and queue the characters it yields.
  function automatic void encode_beat(input logic [b64e_pkg::BYTE_W-1:0] value,
                                      input logic last, input logic [31:0] spelled);
    logic [b64e_pkg::CHAR_W-1:0] out_code [4];
    logic [7:0]                  ch;
    char_beat_t                  beat;
    int                          n;
    int                          k;
    n = 0;
    case (grp_pos)
      GRP_MID: begin
        out_code[n] = sextet_char({held_bits[1:0], value[7:4]});
        n++;
        if (last) begin
          out_code[n] = sextet_char({value[3:0], 2'b00});
          n++;
          out_code[n] = b64e_pkg::PAD_CHAR;
          n++;
          grp_pos   = GRP_LEAD;
          held_bits = '0;
        end else begin
          held_bits = value[3:0];
          grp_pos   = GRP_TAIL;
        end
      end
      GRP_TAIL: begin
        out_code[n] = sextet_char({held_bits, value[7:6]});
        n++;
        out_code[n] = sextet_char(value[5:0]);
        n++;
        grp_pos   = GRP_LEAD;
        held_bits = '0;
      end
      default: begin
        out_code[n] = sextet_char(value[7:2]);
        n++;
        if (last) begin
          out_code[n] = sextet_char({value[1:0], 4'b0000});
          n++;
          out_code[n] = b64e_pkg::PAD_CHAR;
          n++;
          out_code[n] = b64e_pkg::PAD_CHAR;
          n++;
          grp_pos   = GRP_LEAD;
          held_bits = '0;
        end else begin
          held_bits = {2'b00, value[1:0]};
          grp_pos   = GRP_MID;
        end
      end
    endcase

    // A spelled-out row replaces the model's characters with the typed ones.
    if (spelled != 32'd0) begin
      n = 0;
      for (k = 3; k >= 0; k--) begin
        ch = spelled[k*8 +: 8];
        if (ch != 8'd0) begin
          out_code[n] = ch[b64e_pkg::CHAR_W-1:0];
          n++;
        end
      end
    end

    for (k = 0; k < n; k++) begin
      beat.code = out_code[k];
      beat.fin  = last && (k == n - 1);
      expected_chars.insert(expected_chars.size(), beat);
    end
  endfunction

  // Output channel back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    char_out.ready <= no_stall || ($urandom_range(0, 99) >= 25);
  end

  // Score both channels at the rising edge: characters first, then the new byte.
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst) begin
      if (char_out.valid && char_out.ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat: char_code %h final_char %b",
                 char_out.char_code, char_out.final_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (char_out.char_code !== want.code) begin
            $error("char_code: expected %h, got %h", want.code, char_out.char_code);
            mismatches++;
          end
          if (char_out.final_char !== want.fin) begin
            $error("final_char: expected %b, got %b", want.fin, char_out.final_char);
            mismatches++;
          end
        end
      end
      if (byte_in.valid && byte_in.ready) begin
        encode_beat(byte_in.data_byte, byte_in.end_of_message, beat_spelled);
      end
      if ((byte_in.valid && byte_in.ready) || (char_out.valid && char_out.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Give up when nothing moves on either channel for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("base64_stream_encoder_test NOT OK");
    $finish;
  end

  // Offer one byte, with random idle cycles first, and wait for its beat.
  task automatic send_byte(input logic [b64e_pkg::BYTE_W-1:0] value, input logic last,
                           input logic [31:0] spelled);
    @(negedge clk);
    while (!no_stall && $urandom_range(0, 99) < 25) begin
      byte_in.valid <= 1'b0;
      @(negedge clk);
    end
    byte_in.valid          <= 1'b1;
    byte_in.data_byte      <= value;
    byte_in.end_of_message <= last;
    beat_spelled = spelled;
    do @(posedge clk); while (!(byte_in.valid && byte_in.ready));
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  // Hold the input idle until every expected character has come out.
  task automatic drain_output();
    @(negedge clk);
    byte_in.valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
  endtask

  // Pick a byte, leaning on the all-zero and all-one values now and then.
  function automatic logic [b64e_pkg::BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return b64e_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int rand_bytes;
    int msg_len;
    int i;
    rst                    = 1'b1;
    byte_in.valid          = 1'b0;
    byte_in.data_byte      = '0;
    byte_in.end_of_message = 1'b0;
    beat_spelled           = 32'd0;
    no_stall               = 1'b0;
    bytes_sent             = 0;
    messages_sent          = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    for (i = 0; i < DIR_ROWS; i++) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].spelled);
    end
    drain_output();

    // Random messages; one stretch of bytes runs with no stalls on either side.
    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      for (i = 0; i < msg_len; i++) begin
        no_stall = (rand_bytes >= 150) && (rand_bytes < 260);
        send_byte(random_byte(), i == msg_len - 1, 32'd0);
        rand_bytes++;
      end
      if ($urandom_range(0, 5) == 0) drain_output();
    end

    @(negedge clk);
    byte_in.valid <= 1'b0;
    no_stall = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages; %0d characters compared with the model.",
             bytes_sent, messages_sent, chars_checked);
    $display("Messages ended in every group slot, with random stalls on both channels.");
    if (mismatches == 0) begin
      $display("base64_stream_encoder_test OK");
    end else begin
      $display("base64_stream_encoder_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
